@@ hw/rtl/tia_pkg.sv @@
// ----------------------------------------------------------------------------
// tia_pkg
// shared types and codes of the tagged integer alu
// ----------------------------------------------------------------------------
package tia_pkg;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_MOD = 4'd4;
    localparam logic [3:0] OP_LT  = 4'd5;
    localparam logic [3:0] OP_GT  = 4'd6;
    localparam logic [3:0] OP_LTE = 4'd7;
    localparam logic [3:0] OP_GTE = 4'd8;
    localparam logic [3:0] OP_EQ  = 4'd9;
    localparam logic [3:0] OP_AND = 4'd10;

    localparam logic [1:0] TAG_NULL = 2'd0;
    localparam logic [1:0] TAG_INT  = 2'd1;

    localparam int unsigned DW = 64;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [1:0]  a_tag;
        logic [63:0] a_value;
        logic [1:0]  b_tag;
        logic [63:0] b_value;
    } req_t;

    typedef struct packed {
        logic        result_ok;
        logic [63:0] result_value;
        logic        divide_error;
    } res_t;

    // per item control carried down the divider pipe
    typedef struct packed {
        logic        is_div;
        logic        neg_q;
        logic        neg_r;
        logic        ok;
        logic        err;
        logic        use_div;
        logic [63:0] fast_value;
    } ctl_t;

    // partial product of 16x32, 48 bits wide
    typedef logic [47:0] pp_t;

endpackage

@@ hw/rtl/tia_mul.sv @@
// ----------------------------------------------------------------------------
// tia_mul
// 64x64 low product, two stages: 32x32 partial products, sum
// ----------------------------------------------------------------------------
module tia_mul
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0] ll_reg;
    logic [31:0] lh_reg;
    logic [31:0] hl_reg;
    logic [63:0] sum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg  <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
            lh_reg  <= 32'(a[31:0] * b[63:32]);
            hl_reg  <= 32'(a[63:32] * b[31:0]);
            sum_reg <= ll_reg + {lh_reg + hl_reg, 32'd0};
        end
    end

    assign p = sum_reg;

endmodule

@@ hw/rtl/tia_div.sv @@
// ----------------------------------------------------------------------------
// tia_div
// pipelined unsigned radix-2 divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module tia_div
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] n,
    input  logic [63:0] d,
    output logic [63:0] q,
    output logic [63:0] r
);

    localparam int unsigned N = tia_pkg::DW;

    logic [N-1:0] rem_reg [N+1];
    logic [N-1:0] quo_reg [N+1];
    logic [N-1:0] den_reg [N+1];

    always_comb
    begin
        rem_reg[0] = '0;
        quo_reg[0] = n;
        den_reg[0] = d;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [N:0] shifted;
        logic [N:0] diff;
        assign shifted = {rem_reg[i], quo_reg[i][N-1]};
        assign diff    = shifted - {1'b0, den_reg[i]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[i+1] <= den_reg[i];
                if (!diff[N])
                begin
                    rem_reg[i+1] <= diff[N-1:0];
                    quo_reg[i+1] <= {quo_reg[i][N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= shifted[N-1:0];
                    quo_reg[i+1] <= {quo_reg[i][N-2:0], 1'b0};
                end
            end
        end
    end

    assign q = quo_reg[N];
    assign r = rem_reg[N];

endmodule

@@ hw/rtl/tagged_integer_alu_top.sv @@
// ----------------------------------------------------------------------------
// tagged_integer_alu_top
// tagged 64-bit integer alu with type check, fully pipelined
// ----------------------------------------------------------------------------
// one request enters on the s_axis channel, one result leaves on m_axis
// s_axis_tdata: req_type, a_tag, a_value, b_tag, b_value from bit 0 up
// m_axis_tdata: result_ok, result_value, divide_error from bit 0 up
// a result passes from input transfer to output valid through one input
// register, 64 divider stages (one quotient bit each) and the output
// register, which also fixes the sign; the other ops ride along in the same pipe
// throughput is one transfer per cycle while m_axis does not stall
// a stall on m_axis freezes the whole pipe through a global enable, so
// s_axis_tready follows m_axis_tready when the output holds a result
// reset clears all valid bits; payload holds no meaning until valid
// ----------------------------------------------------------------------------
module tagged_integer_alu_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[3:0], a_tag[5:4], a_value[69:6], b_tag[71:70], b_value[135:72]
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_ok[0], result_value[64:1], divide_error[65], zero fill
    output logic [71:0]  m_axis_tdata
);

    localparam int unsigned DEPTH = tia_pkg::DW + 2;

    logic              en;
    logic [DEPTH-1:0]  vld_reg;
    logic [DEPTH-1:0]  vld_next;
    tia_pkg::req_t     req;
    tia_pkg::req_t     in_reg;
    tia_pkg::ctl_t     ctl_in;
    tia_pkg::ctl_t     ctl_reg [tia_pkg::DW+1];
    tia_pkg::res_t     out_reg;
    logic [63:0]       mag_a;
    logic [63:0]       mag_b;
    logic [63:0]       quo;
    logic [63:0]       rem;
    logic [63:0]       prod;
    logic [63:0]       divres;
    logic              ints;
    logic              lt_ab;
    logic              lt_ba;
    logic              ta;
    logic              tb;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign req           = tia_pkg::req_t'({s_axis_tdata[3:0], s_axis_tdata[5:4],
                              s_axis_tdata[69:6], s_axis_tdata[71:70], s_axis_tdata[135:72]});

    always_comb
    begin
        vld_next = {vld_reg[DEPTH-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            in_reg <= req;
    end

    // decode on stage one
    always_comb
    begin
        ints  = in_reg.a_tag == tia_pkg::TAG_INT && in_reg.b_tag == tia_pkg::TAG_INT;
        lt_ab = $signed(in_reg.a_value) < $signed(in_reg.b_value);
        lt_ba = $signed(in_reg.b_value) < $signed(in_reg.a_value);
        ta    = in_reg.a_tag != tia_pkg::TAG_NULL &&
                !(in_reg.a_tag == tia_pkg::TAG_INT && in_reg.a_value == '0);
        tb    = in_reg.b_tag != tia_pkg::TAG_NULL &&
                !(in_reg.b_tag == tia_pkg::TAG_INT && in_reg.b_value == '0);
        mag_a = in_reg.a_value[63] ? 64'(-in_reg.a_value) : in_reg.a_value;
        mag_b = in_reg.b_value[63] ? 64'(-in_reg.b_value) : in_reg.b_value;
        ctl_in            = '0;
        ctl_in.is_div     = in_reg.req_type == tia_pkg::OP_DIV;
        ctl_in.neg_q      = in_reg.a_value[63] ^ in_reg.b_value[63];
        ctl_in.neg_r      = in_reg.a_value[63];
        if (in_reg.req_type == tia_pkg::OP_AND)
        begin
            ctl_in.ok         = 1'b1;
            ctl_in.fast_value = {63'd0, ta && tb};
        end
        else if (in_reg.req_type <= tia_pkg::OP_EQ && ints)
        begin
            ctl_in.ok = 1'b1;
            case (in_reg.req_type)
                tia_pkg::OP_ADD: ctl_in.fast_value = in_reg.a_value + in_reg.b_value;
                tia_pkg::OP_SUB: ctl_in.fast_value = in_reg.a_value - in_reg.b_value;
                tia_pkg::OP_DIV,
                tia_pkg::OP_MOD:
                begin
                    if (in_reg.b_value == '0)
                        ctl_in.err = 1'b1;
                    else
                        ctl_in.use_div = 1'b1;
                end
                tia_pkg::OP_LT:  ctl_in.fast_value = {63'd0, lt_ab};
                tia_pkg::OP_GT:  ctl_in.fast_value = {63'd0, lt_ba};
                tia_pkg::OP_LTE: ctl_in.fast_value = {63'd0, !lt_ba};
                tia_pkg::OP_GTE: ctl_in.fast_value = {63'd0, !lt_ab};
                tia_pkg::OP_EQ:  ctl_in.fast_value = {63'd0, in_reg.a_value == in_reg.b_value};
                default:         ctl_in.fast_value = '0;
            endcase
        end
    end

    always_comb
    begin
        ctl_reg[0] = ctl_in;
    end

    for (genvar i = 0; i < tia_pkg::DW; i++)
    begin : g_ctl
        always_ff @(posedge clk)
        begin
            if (en)
                ctl_reg[i+1] <= ctl_reg[i];
        end
    end

    tia_div u_div
    (
        .clk (clk),
        .en  (en),
        .n   (mag_a),
        .d   (mag_b),
        .q   (quo),
        .r   (rem)
    );

    // product ready two stages after stage one, delayed to the end below
    tia_mul u_mul
    (
        .clk (clk),
        .en  (en),
        .a   (in_reg.a_value),
        .b   (in_reg.b_value),
        .p   (prod)
    );

    logic [63:0] prod_dly_reg [tia_pkg::DW-2];
    logic        mul_sel_reg  [tia_pkg::DW+1];

    always_comb
    begin
        mul_sel_reg[0] = in_reg.req_type == tia_pkg::OP_MUL && ints;
    end

    for (genvar i = 0; i < tia_pkg::DW; i++)
    begin : g_msel
        always_ff @(posedge clk)
        begin
            if (en)
                mul_sel_reg[i+1] <= mul_sel_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prod_dly_reg[0] <= prod;
    end

    for (genvar i = 1; i < tia_pkg::DW - 2; i++)
    begin : g_pdly
        always_ff @(posedge clk)
        begin
            if (en)
                prod_dly_reg[i] <= prod_dly_reg[i-1];
        end
    end

    always_comb
    begin
        if (ctl_reg[tia_pkg::DW].is_div)
            divres = ctl_reg[tia_pkg::DW].neg_q ? 64'(-quo) : quo;
        else
            divres = ctl_reg[tia_pkg::DW].neg_r ? 64'(-rem) : rem;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.result_ok    <= ctl_reg[tia_pkg::DW].ok;
            out_reg.divide_error <= ctl_reg[tia_pkg::DW].err;
            if (ctl_reg[tia_pkg::DW].use_div)
                out_reg.result_value <= divres;
            else if (mul_sel_reg[tia_pkg::DW])
                out_reg.result_value <= prod_dly_reg[tia_pkg::DW-3];
            else
                out_reg.result_value <= ctl_reg[tia_pkg::DW].fast_value;
        end
    end

    assign m_axis_tvalid = vld_reg[DEPTH-1];
    assign m_axis_tdata  = {6'd0, out_reg.divide_error, out_reg.result_value,
                            out_reg.result_ok};

endmodule

@@ hw/rtl/tia_checker.sv @@
// ----------------------------------------------------------------------------
// tia_checker
// port level checks of the tagged integer alu
// ----------------------------------------------------------------------------
module tia_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [135:0] s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [71:0]  m_axis_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");

    a_err_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[65] |-> m_axis_tdata[0] && m_axis_tdata[64:1] == '0)
        else $error("divide error without zero integer result");

    a_null: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[64:1] == '0)
        else $error("null result carries a value");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_known_in: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid |-> !$isunknown(s_axis_tdata))
        else $error("unknown bits in input transfer");

endmodule

bind tagged_integer_alu_top tia_checker u_tia_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ bench/tagged_integer_alu_top_test.sv @@
// ----------------------------------------------------------------------------
// tagged_integer_alu_top_test
// drives tagged requests through the alu stream and compares every result
// with an independent prediction of type check, wrap and division rules
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tagged_integer_alu_top_test;

    typedef struct packed {
        logic        ok;
        logic [63:0] value;
        logic        err;
    } alu_result_t;

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
    localparam logic [1:0]  TAG_OTHER = 2'd2;
    localparam logic [1:0]  TAG_SPARE = 2'd3;
    localparam int          STALL_LIMIT = 5000;

    class result_board;
        alu_result_t pending[$];
        int          errors = 0;

        function automatic logic truthy(logic [1:0] tag, logic [63:0] v);
            if (tag == tia_pkg::TAG_NULL)
                return 1'b0;
            if (tag == tia_pkg::TAG_INT && v == 64'd0)
                return 1'b0;
            return 1'b1;
        endfunction

        function automatic alu_result_t compute(tia_pkg::req_t r);
            alu_result_t x;
            logic signed [63:0] sa;
            logic signed [63:0] sb;
            logic [63:0] ua;
            logic [63:0] ub;
            logic [63:0] q;
            x = '0;
            sa = r.a_value;
            sb = r.b_value;
            if (r.req_type == tia_pkg::OP_AND)
            begin
                x.ok = 1'b1;
                x.value = {63'd0, truthy(r.a_tag, r.a_value) & truthy(r.b_tag, r.b_value)};
            end
            else if (r.req_type <= tia_pkg::OP_EQ && r.a_tag == tia_pkg::TAG_INT &&
                     r.b_tag == tia_pkg::TAG_INT)
            begin
                x.ok = 1'b1;
                case (r.req_type)
                    tia_pkg::OP_ADD: x.value = r.a_value + r.b_value;
                    tia_pkg::OP_SUB: x.value = r.a_value - r.b_value;
                    tia_pkg::OP_MUL: x.value = r.a_value * r.b_value;
                    tia_pkg::OP_DIV, tia_pkg::OP_MOD:
                    begin
                        if (r.b_value == 64'd0)
                            x.err = 1'b1;
                        else
                        begin
                            ua = sa[63] ? -r.a_value : r.a_value;
                            ub = sb[63] ? -r.b_value : r.b_value;
                            if (r.req_type == tia_pkg::OP_DIV)
                            begin
                                q = ua / ub;
                                x.value = (sa[63] != sb[63]) ? -q : q;
                            end
                            else
                            begin
                                q = ua % ub;
                                x.value = sa[63] ? -q : q;
                            end
                        end
                    end
                    tia_pkg::OP_LT:  x.value = {63'd0, sa < sb};
                    tia_pkg::OP_GT:  x.value = {63'd0, sa > sb};
                    tia_pkg::OP_LTE: x.value = {63'd0, sa <= sb};
                    tia_pkg::OP_GTE: x.value = {63'd0, sa >= sb};
                    default: x.value = {63'd0, r.a_value == r.b_value};
                endcase
            end
            return x;
        endfunction

        function void note_request(tia_pkg::req_t r);
            pending.push_back(compute(r));
        endfunction

        function void check_result(logic [71:0] data);
            alu_result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("result transfer with nothing pending");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (data[0] !== exp_r.ok)
            begin
                $error("result_ok expected %0d actual %0d", exp_r.ok, data[0]);
                errors++;
            end
            if (data[64:1] !== exp_r.value)
            begin
                $error("result_value expected %h actual %h", exp_r.value, data[64:1]);
                errors++;
            end
            if (data[65] !== exp_r.err)
            begin
                $error("divide_error expected %0d actual %0d", exp_r.err, data[65]);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;

    result_board board;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  quiet_cycles;
    bit  timed_out;

    tagged_integer_alu_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // receiver side, check on rising edge, new ready at falling edge
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
        if (rst_n && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("tagged_integer_alu_top: mismatch");
            $finish;
        end
    end

    task automatic send_request(tia_pkg::req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.b_value, r.b_tag, r.a_value, r.a_tag, r.req_type};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_request(r);
        @(negedge clk);
    endtask

    task automatic send_fields(logic [3:0] op, logic [1:0] at, logic [63:0] a,
                               logic [1:0] bt, logic [63:0] b);
        tia_pkg::req_t r;
        r = '{req_type: op, a_tag: at, a_value: a, b_tag: bt, b_value: b};
        send_request(r);
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        case ($urandom_range(7))
            0: v = 64'd0;
            1: v = MIN64;
            2: v = MAX64;
            3: v = {64{1'b1}};
            4: v = 64'(signed'($urandom_range(20)) - 10);
            5: v = {32'd0, $urandom};
            6: v = {{32{1'b1}}, $urandom};
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic random_phase(int count);
        logic [3:0] op;
        logic [1:0] at;
        logic [1:0] bt;
        repeat (count)
        begin
            op = ($urandom_range(15) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(10));
            at = ($urandom_range(9) < 8) ? tia_pkg::TAG_INT : 2'($urandom_range(3));
            bt = ($urandom_range(9) < 8) ? tia_pkg::TAG_INT : 2'($urandom_range(3));
            send_fields(op, at, pick_value(), bt, pick_value());
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed corners
        send_fields(tia_pkg::OP_ADD, tia_pkg::TAG_INT, MAX64, tia_pkg::TAG_INT, 64'd1);
        send_fields(tia_pkg::OP_SUB, tia_pkg::TAG_INT, MIN64, tia_pkg::TAG_INT, 64'd1);
        send_fields(tia_pkg::OP_MUL, tia_pkg::TAG_INT, MAX64, tia_pkg::TAG_INT, MAX64);
        send_fields(tia_pkg::OP_DIV, tia_pkg::TAG_INT, MIN64, tia_pkg::TAG_INT, {64{1'b1}});
        send_fields(tia_pkg::OP_MOD, tia_pkg::TAG_INT, MIN64, tia_pkg::TAG_INT, {64{1'b1}});
        send_fields(tia_pkg::OP_DIV, tia_pkg::TAG_INT, 64'd7, tia_pkg::TAG_INT, 64'd0);
        send_fields(tia_pkg::OP_MOD, tia_pkg::TAG_INT, 64'd7, tia_pkg::TAG_INT, 64'd0);
        send_fields(tia_pkg::OP_DIV, tia_pkg::TAG_INT, -64'd7, tia_pkg::TAG_INT, 64'd2);
        send_fields(tia_pkg::OP_MOD, tia_pkg::TAG_INT, -64'd7, tia_pkg::TAG_INT, 64'd2);
        send_fields(tia_pkg::OP_MOD, tia_pkg::TAG_INT, 64'd7, tia_pkg::TAG_INT, -64'd2);
        send_fields(tia_pkg::OP_LT, tia_pkg::TAG_INT, MIN64, tia_pkg::TAG_INT, MAX64);
        send_fields(tia_pkg::OP_GT, tia_pkg::TAG_INT, MIN64, tia_pkg::TAG_INT, MAX64);
        send_fields(tia_pkg::OP_LTE, tia_pkg::TAG_INT, 64'd5, tia_pkg::TAG_INT, 64'd5);
        send_fields(tia_pkg::OP_GTE, tia_pkg::TAG_INT, -64'd1, tia_pkg::TAG_INT, 64'd0);
        send_fields(tia_pkg::OP_EQ, tia_pkg::TAG_INT, MIN64, tia_pkg::TAG_INT, MIN64);
        send_fields(tia_pkg::OP_ADD, tia_pkg::TAG_NULL, 64'd1, tia_pkg::TAG_INT, 64'd2);
        send_fields(tia_pkg::OP_DIV, TAG_OTHER, 64'd1, tia_pkg::TAG_INT, 64'd0);
        send_fields(tia_pkg::OP_EQ, tia_pkg::TAG_INT, 64'd1, TAG_SPARE, 64'd1);
        send_fields(tia_pkg::OP_AND, tia_pkg::TAG_NULL, 64'd1, tia_pkg::TAG_INT, 64'd1);
        send_fields(tia_pkg::OP_AND, tia_pkg::TAG_INT, 64'd0, tia_pkg::TAG_INT, 64'd1);
        send_fields(tia_pkg::OP_AND, TAG_OTHER, 64'd0, TAG_SPARE, 64'd0);
        send_fields(tia_pkg::OP_AND, tia_pkg::TAG_INT, MIN64, tia_pkg::TAG_INT, {64{1'b1}});
        send_fields(4'd11, tia_pkg::TAG_INT, 64'd1, tia_pkg::TAG_INT, 64'd1);
        send_fields(4'd15, tia_pkg::TAG_INT, MAX64, tia_pkg::TAG_INT, MIN64);

        random_phase(350);
        // hold off until the pipe is empty
        drain();
        send_idle_pct = 63;
        random_phase(350);
        send_idle_pct = 0;
        recv_stall_pct = 63;
        random_phase(350);
        send_idle_pct = 37;
        recv_stall_pct = 37;
        random_phase(350);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(50);

        drain();
        repeat (80) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tagged_integer_alu_top: match");
        else
            $display("tagged_integer_alu_top: mismatch");
        $finish;
    end

endmodule

@@ tagged_integer_alu_top.f @@
hw/rtl/tia_pkg.sv
hw/rtl/tia_mul.sv
hw/rtl/tia_div.sv
hw/rtl/tagged_integer_alu_top.sv
hw/rtl/tia_checker.sv
bench/tagged_integer_alu_top_test.sv
